/* rtl/core/dttd_pkg.sv */
// ----------------------------------------------------------------------------
// Decimal text to double: shared package
// Types, operation codes and floating-point constants used by the parser
// sequencer and the shared floating-point unit.
// ----------------------------------------------------------------------------
package dttd_pkg;

  // Operations of the shared floating-point unit.
  localparam logic [1:0] OP_MUL10 = 2'd0;  // a * 10.0
  localparam logic [1:0] OP_MUL01 = 2'd1;  // a * 0.1
  localparam logic [1:0] OP_ADD   = 2'd2;  // a + digit

  // Significand of the binary64 value nearest 0.1 (0.1 = sig * 2^-56).
  localparam logic [52:0] ONE_TENTH_SIG = 53'h1999999999999A;

  localparam logic [63:0] DBL_INF = 64'h7FF0000000000000;
  localparam logic [31:0] FLT_INF = 32'h7F800000;

  // Saturation limit of the decimal exponent counters.
  localparam int unsigned EXP_W = 12;
  localparam logic [EXP_W-1:0] EXP_LIMIT = 12'd2047;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
    logic [3:0] digit;
  } fpu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } fpu_stat_t;

endpackage

/* rtl/core/dttd_fpu.sv */
// ----------------------------------------------------------------------------
// Shared floating-point unit
// Multi-cycle binary64 unit for non-negative operands: multiply by 10.0,
// multiply by 0.1 (nibble-serial) and add a small digit, each rounded to
// nearest even, with iterative normalisation and subnormal handling.
// ----------------------------------------------------------------------------
module dttd_fpu import dttd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  fpu_req_t    req,
  input  logic [63:0] operand,
  output fpu_stat_t   stat,
  output logic [63:0] result
);

  localparam logic [2:0] F_IDLE   = 3'd0;
  localparam logic [2:0] F_MUL    = 3'd1;
  localparam logic [2:0] F_NORM   = 3'd2;
  localparam logic [2:0] F_DENORM = 3'd3;
  localparam logic [2:0] F_ROUND  = 3'd4;

  logic [2:0]         fstate;
  logic               done;
  // Working value: bit 127 carries weight 2^ex.
  logic [127:0]       n;
  logic signed [12:0] ex;
  logic [52:0]        sig;
  logic [3:0]         k;

  logic [10:0]        op_e;
  logic [52:0]        op_sig;
  logic signed [12:0] eeff_s;
  logic [56:0]        p10;
  logic signed [12:0] exa;
  logic [12:0]        sh_full;
  logic [127:0]       base;
  logic [127:0]       dshift;
  logic [55:0]        tenth56;
  logic [3:0]         nib;
  logic [56:0]        pp;
  logic [105:0]       t;
  logic [52:0]        mant;
  logic               inc;
  logic [53:0]        rm;
  logic signed [12:0] bexp;
  logic [63:0]        rnd_res;

  always_comb begin
    op_e    = operand[62:52];
    op_sig  = {|op_e, operand[51:0]};
    eeff_s  = (op_e == 11'd0) ? 13'sd1 : $signed({2'b00, op_e});
    p10     = {1'b0, op_sig, 3'b000} + {3'b000, op_sig, 1'b0};
    exa     = $signed({2'b00, op_e}) - 13'sd1022;
    sh_full = 13'(13'sd127 - exa);
    base    = {1'b0, op_sig, 74'd0};
    dshift  = {124'd0, req.digit} << sh_full[6:0];
    tenth56 = {3'b000, ONE_TENTH_SIG};
    nib     = tenth56[{k, 2'b00} +: 4];
    pp      = {4'b0000, sig} * {53'd0, nib};
    t       = {n[101:0], 4'b0000} + {49'd0, pp};

    mant = n[127:75];
    inc  = n[74] & ((|n[73:0]) | mant[0]);
    rm   = {1'b0, mant} + {53'd0, inc};
    bexp = ex + 13'sd1023 + $signed({12'd0, rm[53]});
    if (!rm[53] && !rm[52]) begin
      rnd_res = {12'd0, rm[51:0]};
    end else if (bexp >= 13'sd2047) begin
      rnd_res = DBL_INF;
    end else begin
      rnd_res = {1'b0, bexp[10:0], (rm[53] ? rm[52:1] : rm[51:0])};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= F_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (fstate)
        F_IDLE: begin
          if (req.start) begin
            if (op_e == 11'h7FF) begin
              // Infinity is unchanged by every operation here.
              result <= operand;
              done   <= 1'b1;
            end else begin
              case (req.op)
                OP_MUL10: begin
                  n      <= {p10, 71'd0};
                  ex     <= eeff_s - 13'sd1019;
                  fstate <= F_NORM;
                end
                OP_MUL01: begin
                  sig    <= op_sig;
                  n      <= 128'd0;
                  k      <= 4'd13;
                  ex     <= eeff_s - 13'sd1026;
                  fstate <= F_MUL;
                end
                default: begin
                  // The accumulator is always an integer, so it is zero
                  // or at least one.
                  if (op_e == 11'd0) begin
                    n  <= {req.digit, 124'd0};
                    ex <= 13'sd3;
                  end else if (exa >= 13'sd120) begin
                    n  <= base | {127'd0, (req.digit != 4'd0)};
                    ex <= exa;
                  end else begin
                    n  <= base + dshift;
                    ex <= exa;
                  end
                  fstate <= F_NORM;
                end
              endcase
            end
          end
        end
        F_MUL: begin
          if (k == 4'd0) begin
            n      <= {t, 22'd0};
            fstate <= F_NORM;
          end else begin
            n <= {22'd0, t};
            k <= k - 4'd1;
          end
        end
        F_NORM: begin
          if (n == 128'd0 || n[127]) begin
            fstate <= F_DENORM;
          end else if (n[127:120] == 8'd0) begin
            n  <= {n[119:0], 8'd0};
            ex <= ex - 13'sd8;
          end else begin
            n  <= {n[126:0], 1'b0};
            ex <= ex - 13'sd1;
          end
        end
        F_DENORM: begin
          if (n == 128'd0 || ex >= -13'sd1022) begin
            fstate <= F_ROUND;
          end else if (ex <= -13'sd1030) begin
            n  <= {8'd0, n[127:9], n[8] | (|n[7:0])};
            ex <= ex + 13'sd8;
          end else begin
            n  <= {1'b0, n[127:2], n[1] | n[0]};
            ex <= ex + 13'sd1;
          end
        end
        F_ROUND: begin
          result <= rnd_res;
          done   <= 1'b1;
          fstate <= F_IDLE;
        end
        default: fstate <= F_IDLE;
      endcase
    end
  end

  assign stat.busy = (fstate != F_IDLE);
  assign stat.done = done;

endmodule

/* rtl/core/decimal_text_to_double.sv */
// A character that is not a mantissa digit is handled by the parser alone; a
// mantissa digit takes a multiply by 10.0 and an add in the shared unit (an
// infinite value passes through both unchanged).
// The item marked last then has its exponent formed and adds |e| scaling
// multiplies (e up to 4094) by 10.0 or by 0.1, then the conversion to single and the output register.
// Items are taken one at a time, only while idle; the shared floating-point unit and the output register hold the flow.
// Reset is synchronous and clears the parser to the integer-digit phase, +0.0.
// ----------------------------------------------------------------------------
// Decimal text to double: top level
// Parses a decimal string one character per transfer and, on the last
// transfer, returns its binary64 value and that value rounded to binary32.
// ----------------------------------------------------------------------------
module decimal_text_to_double import dttd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] value_double,
  output logic [31:0] value_single
);

  // Parser phases.
  localparam logic [2:0] PH_INT      = 3'd0;
  localparam logic [2:0] PH_FRAC     = 3'd1;
  localparam logic [2:0] PH_EXPSTART = 3'd2;
  localparam logic [2:0] PH_EXPDIG   = 3'd3;
  localparam logic [2:0] PH_DONE     = 3'd4;

  // Sequencer states.
  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_DIG_MUL    = 3'd1;
  localparam logic [2:0] S_DIG_ADD    = 3'd2;
  localparam logic [2:0] S_EXP        = 3'd3;
  localparam logic [2:0] S_SCALE_GO   = 3'd4;
  localparam logic [2:0] S_SCALE_WAIT = 3'd5;
  localparam logic [2:0] S_CONV       = 3'd6;
  localparam logic [2:0] S_EMIT       = 3'd7;

  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_LE  = 8'h65;
  localparam logic [7:0] CH_UE  = 8'h45;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  logic [2:0]       state;
  logic [2:0]       phase;
  logic [63:0]      acc;
  logic [EXP_W-1:0] fc;       // fraction digit count, the negated decimal exponent
  logic [EXP_W-1:0] ed;       // magnitude of the written exponent
  logic             eneg;
  logic             last_q;
  logic [3:0]       dig_q;
  logic [12:0]      cnt;
  logic             scale_neg;
  logic [31:0]      single_q;

  logic [2:0]       phase_next;
  logic [EXP_W-1:0] fc_next;
  logic [EXP_W-1:0] ed_next;
  logic             eneg_next;
  logic             do_add;
  logic             is_dig;
  logic             is_e;
  logic [7:0]       dsub;
  logic [3:0]       dval;
  logic [15:0]      ed_mul;
  logic [EXP_W-1:0] ed_sat;
  logic             accept;
  logic             emit_go;

  logic signed [13:0] ed_s;
  logic signed [13:0] e_tot;
  logic [13:0]        e_mag;

  fpu_req_t    fpu_req;
  fpu_stat_t   fpu_stat;
  logic [63:0] fpu_operand;
  logic [63:0] fpu_result;

  function automatic logic [31:0] to_single(input logic [63:0] d);
    logic [10:0]        e;
    logic [52:0]        m;
    logic signed [12:0] u;
    logic [23:0]        keep;
    logic               inc;
    logic [24:0]        rm;
    logic [12:0]        be_full;
    logic [8:0]         be;
    logic [12:0]        sh_full;
    logic [105:0]       ext;
    logic [52:0]        q;
    logic               inc2;
    logic [31:0]        r;
    e       = d[62:52];
    m       = {1'b1, d[51:0]};
    u       = $signed({2'b00, e}) - 13'sd1023;
    keep    = m[52:29];
    inc     = m[28] & ((|m[27:0]) | keep[0]);
    rm      = {1'b0, keep} + {24'd0, inc};
    be_full = 13'(u + 13'sd127);
    be      = be_full[8:0] + {8'd0, rm[24]};
    sh_full = 13'(-13'sd97 - u);
    ext     = {m, 53'd0} >> sh_full[5:0];
    q       = ext[105:53];
    inc2    = ext[52] & ((|ext[51:0]) | q[0]);
    if (e == 11'h7FF) begin
      r = FLT_INF;
    end else if (e == 11'd0) begin
      r = 32'd0;
    end else if (u > 13'sd127) begin
      r = FLT_INF;
    end else if (u >= -13'sd126) begin
      if (be >= 9'd255) begin
        r = FLT_INF;
      end else begin
        r = {1'b0, be[7:0], (rm[24] ? rm[23:1] : rm[22:0])};
      end
    end else if (u < -13'sd150) begin
      r = 32'd0;
    end else begin
      // Subnormal result; a carry out of the fraction gives the smallest normal.
      r = q[31:0] + {31'd0, inc2};
    end
    return r;
  endfunction

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid & in_ready;
  assign emit_go  = (state == S_EMIT) && (!out_valid || out_ready);

  // Character classification and the next parser state for this character.
  always_comb begin
    phase_next = phase;
    fc_next    = fc;
    ed_next    = ed;
    eneg_next  = eneg;
    do_add     = 1'b0;
    is_dig     = ch inside {[CH_0:CH_9]};
    is_e       = (ch == CH_LE) || (ch == CH_UE);
    dsub       = ch - CH_0;
    dval       = dsub[3:0];
    ed_mul     = ({4'd0, ed} << 3) + ({4'd0, ed} << 1) + {12'd0, dval};
    ed_sat     = (ed_mul > {4'd0, EXP_LIMIT}) ? EXP_LIMIT : ed_mul[EXP_W-1:0];
    case (phase)
      PH_INT: begin
        if (is_dig) begin
          do_add = 1'b1;
        end else if (ch == CH_DOT) begin
          phase_next = PH_FRAC;
        end else if (is_e) begin
          phase_next = PH_EXPSTART;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_FRAC: begin
        if (is_dig) begin
          do_add = 1'b1;
          if (fc < EXP_LIMIT) begin
            fc_next = fc + 12'd1;
          end
        end else if (is_e) begin
          phase_next = PH_EXPSTART;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_EXPSTART: begin
        if (ch == CH_PLUS) begin
          phase_next = PH_EXPDIG;
        end else if (ch == CH_MINUS) begin
          eneg_next  = 1'b1;
          phase_next = PH_EXPDIG;
        end else if (is_dig) begin
          ed_next    = ed_sat;
          phase_next = PH_EXPDIG;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_EXPDIG: begin
        if (is_dig) begin
          ed_next = ed_sat;
        end else begin
          phase_next = PH_DONE;
        end
      end
      default: ;
    endcase
  end

  // Total decimal exponent: written exponent less the fraction digit count.
  always_comb begin
    ed_s  = eneg ? -$signed({2'b00, ed}) : $signed({2'b00, ed});
    e_tot = ed_s - $signed({2'b00, fc});
    e_mag = (e_tot < 14'sd0) ? 14'(-e_tot) : 14'(e_tot);
  end

  // Requests to the shared unit: a digit starts with the multiply by ten,
  // whose result feeds the add straight away; scaling reuses the accumulator.
  always_comb begin
    fpu_req.start = 1'b0;
    fpu_req.op    = OP_MUL10;
    fpu_req.digit = dig_q;
    fpu_operand   = acc;
    if (accept && do_add) begin
      fpu_req.start = 1'b1;
    end else if (state == S_DIG_MUL && fpu_stat.done) begin
      fpu_req.start = 1'b1;
      fpu_req.op    = OP_ADD;
      fpu_operand   = fpu_result;
    end else if (state == S_SCALE_GO && cnt != 13'd0) begin
      fpu_req.start = 1'b1;
      fpu_req.op    = scale_neg ? OP_MUL01 : OP_MUL10;
    end
  end

  dttd_fpu u_fpu (
    .clk     (clk),
    .rst     (rst),
    .req     (fpu_req),
    .operand (fpu_operand),
    .stat    (fpu_stat),
    .result  (fpu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_INT;
      acc       <= 64'd0;
      fc        <= '0;
      ed        <= '0;
      eneg      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // The output register is loaded when free or being emptied, else it
      // empties once its transfer takes place.
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            phase  <= phase_next;
            fc     <= fc_next;
            ed     <= ed_next;
            eneg   <= eneg_next;
            last_q <= last;
            dig_q  <= dval;
            if (do_add) begin
              state <= S_DIG_MUL;
            end else if (last) begin
              state <= S_EXP;
            end
          end
        end
        S_DIG_MUL: begin
          if (fpu_stat.done) begin
            acc   <= fpu_result;
            state <= S_DIG_ADD;
          end
        end
        S_DIG_ADD: begin
          if (fpu_stat.done) begin
            acc   <= fpu_result;
            state <= last_q ? S_EXP : S_IDLE;
          end
        end
        S_EXP: begin
          cnt       <= e_mag[12:0];
          scale_neg <= e_tot[13];
          state     <= S_SCALE_GO;
        end
        S_SCALE_GO: begin
          state <= (cnt == 13'd0) ? S_CONV : S_SCALE_WAIT;
        end
        S_SCALE_WAIT: begin
          if (fpu_stat.done) begin
            acc   <= fpu_result;
            cnt   <= cnt - 13'd1;
            state <= S_SCALE_GO;
          end
        end
        S_CONV: begin
          single_q <= to_single(acc);
          state    <= S_EMIT;
        end
        S_EMIT: begin
          // The result register is free or being emptied: load it and start
          // the next string from the reset state.
          if (emit_go) begin
            value_double <= acc;
            value_single <= single_q;
            phase        <= PH_INT;
            acc          <= 64'd0;
            fc           <= '0;
            ed           <= '0;
            eneg         <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The shared unit is only started when it is free.
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    fpu_req.start |-> !fpu_stat.busy)
    else $error("shared unit started while busy");

  // A result from the shared unit only arrives while the sequencer waits for one.
  a_done_waited: assert property (@(posedge clk) disable iff (rst)
    fpu_stat.done |-> (state == S_DIG_MUL || state == S_DIG_ADD ||
                       state == S_SCALE_WAIT))
    else $error("shared unit result arrived unexpectedly");

  // Scaling finishes once the multiply count is exhausted.
  a_scale_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCALE_GO && cnt == 13'd0) |=> state == S_CONV)
    else $error("scaling did not finish");

  // Loading the result always presents it on the output.
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    emit_go |=> (out_valid && state == S_IDLE && phase == PH_INT))
    else $error("result not presented after load");

endmodule
